[hw/rtl/ll1ep_pkg.sv]
// Shared codes, types and grammar tables for the LL(1) expression parser.
`timescale 1ns / 1ps

package ll1ep_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int TOP_W       = $clog2(STACK_DEPTH);

  // Grammar symbols as held on the stack
  localparam logic [3:0] SYM_END  = 4'd0;
  localparam logic [3:0] SYM_E    = 4'd1;
  localparam logic [3:0] SYM_EP   = 4'd2;
  localparam logic [3:0] SYM_T    = 4'd3;
  localparam logic [3:0] SYM_TP   = 4'd4;
  localparam logic [3:0] SYM_F    = 4'd5;
  localparam logic [3:0] SYM_ID   = 4'd6;
  localparam logic [3:0] SYM_PLUS = 4'd7;
  localparam logic [3:0] SYM_STAR = 4'd8;
  localparam logic [3:0] SYM_LP   = 4'd9;
  localparam logic [3:0] SYM_RP   = 4'd10;
  localparam logic [3:0] SYM_BAD  = 4'd15;

  // Result events
  localparam logic [2:0] EV_PROD   = 3'd0;
  localparam logic [2:0] EV_MATCH  = 3'd1;
  localparam logic [2:0] EV_ACCEPT = 3'd2;
  localparam logic [2:0] EV_BADCH  = 3'd3;
  localparam logic [2:0] EV_SYNTAX = 3'd4;
  localparam logic [2:0] EV_OVF    = 3'd5;

  // Stack operations
  localparam logic [1:0] STK_NONE   = 2'd0;
  localparam logic [1:0] STK_POP    = 2'd1;
  localparam logic [1:0] STK_EXPAND = 2'd2;
  localparam logic [1:0] STK_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] rule;
  } stack_cmd_t;

  typedef struct packed {
    logic [3:0]       top_sym;
    logic [TOP_W-1:0] top_idx;
  } stack_stat_t;

  // Microcode: jump conditions and control word
  localparam logic [1:0] JC_IN_BEAT = 2'd0;  // jump once an input beat lands
  localparam logic [1:0] JC_LAST    = 2'd1;  // jump once the last result is issued
  localparam logic [1:0] JC_ALWAYS  = 2'd2;

  localparam int UC_W = 1;

  typedef struct packed {
    logic            in_rdy;
    logic            exec;
    logic [1:0]      jc;
    logic [UC_W-1:0] target;
  } ucode_t;

  localparam logic [UC_W-1:0] UC_FETCH = 1'd0;
  localparam logic [UC_W-1:0] UC_STEP  = 1'd1;

  function automatic ucode_t ucode_rom(input logic [UC_W-1:0] step);
    ucode_t w;
    unique case (step)
      UC_FETCH: w = '{in_rdy: 1'b1, exec: 1'b0, jc: JC_IN_BEAT, target: UC_STEP};
      UC_STEP:  w = '{in_rdy: 1'b0, exec: 1'b1, jc: JC_LAST,    target: UC_FETCH};
      default:  w = '{in_rdy: 1'b0, exec: 1'b0, jc: JC_ALWAYS,  target: UC_FETCH};
    endcase
    return w;
  endfunction

  function automatic logic [3:0] classify(input logic [7:0] c);
    logic [3:0] s;
    if ((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a)) begin
      s = SYM_ID;
    end else begin
      unique case (c)
        8'h2b:   s = SYM_PLUS;
        8'h2a:   s = SYM_STAR;
        8'h28:   s = SYM_LP;
        8'h29:   s = SYM_RP;
        8'h23:   s = SYM_END;
        default: s = SYM_BAD;
      endcase
    end
    return s;
  endfunction

  // Parse table: row is the nonterminal, column the lookahead terminal
  function automatic logic [3:0] parse_rule(input logic [3:0] nt, input logic [3:0] la);
    logic [3:0] r;
    r = 4'd0;
    unique case (nt)
      SYM_E:   if (la == SYM_ID || la == SYM_LP) r = 4'd1;
      SYM_EP: begin
        if (la == SYM_PLUS) r = 4'd2;
        else if (la == SYM_RP || la == SYM_END) r = 4'd3;
      end
      SYM_T:   if (la == SYM_ID || la == SYM_LP) r = 4'd4;
      SYM_TP: begin
        if (la == SYM_STAR) r = 4'd5;
        else if (la == SYM_PLUS || la == SYM_RP || la == SYM_END) r = 4'd6;
      end
      SYM_F: begin
        if (la == SYM_ID) r = 4'd8;
        else if (la == SYM_LP) r = 4'd7;
      end
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] rhs_len(input logic [3:0] rule);
    logic [1:0] n;
    unique case (rule)
      4'd1, 4'd4:       n = 2'd2;
      4'd2, 4'd5, 4'd7: n = 2'd3;
      4'd8:             n = 2'd1;
      default:          n = 2'd0;
    endcase
    return n;
  endfunction

  // Right-hand side, last symbol first (slot 0 lands deepest)
  function automatic logic [3:0] rhs_sym(input logic [3:0] rule, input logic [1:0] slot);
    logic [3:0] s;
    s = SYM_END;
    unique case (rule)
      4'd1:    s = (slot == 2'd0) ? SYM_EP : SYM_T;
      4'd2:    s = (slot == 2'd0) ? SYM_EP : (slot == 2'd1) ? SYM_T : SYM_PLUS;
      4'd4:    s = (slot == 2'd0) ? SYM_TP : SYM_F;
      4'd5:    s = (slot == 2'd0) ? SYM_TP : (slot == 2'd1) ? SYM_F : SYM_STAR;
      4'd7:    s = (slot == 2'd0) ? SYM_RP : (slot == 2'd1) ? SYM_E : SYM_LP;
      4'd8:    s = SYM_ID;
      default: s = SYM_END;
    endcase
    return s;
  endfunction

endpackage

[hw/rtl/ll1ep_stack.sv]
// Symbol stack of the parser: expand, pop and clear, one operation per cycle.
`timescale 1ns / 1ps

module ll1ep_stack (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ll1ep_pkg::stack_cmd_t  cmd_i,
  output ll1ep_pkg::stack_stat_t stat_o
);

  localparam int DW = ll1ep_pkg::STACK_DEPTH;
  localparam int TW = ll1ep_pkg::TOP_W;

  logic [3:0]    stack_q [DW];
  logic [3:0]    stack_d [DW];
  logic [TW-1:0] top_q, top_d;
  logic [1:0]    len;
  logic [TW:0]   widx [3];

  assign len = ll1ep_pkg::rhs_len(cmd_i.rule);

  always_comb begin
    stack_d = stack_q;
    top_d   = top_q;
    for (int i = 0; i < 3; i++) begin
      widx[i] = {1'b0, top_q} + (TW+1)'(i);
    end
    unique case (cmd_i.op)
      ll1ep_pkg::STK_POP: begin
        top_d = (top_q != '0) ? top_q - TW'(1) : '0;
      end
      ll1ep_pkg::STK_EXPAND: begin
        // Caller has already ruled out overflow and empty right-hand sides
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < len && widx[i] < (TW+1)'(DW)) begin
            stack_d[widx[i][TW-1:0]] = ll1ep_pkg::rhs_sym(cmd_i.rule, 2'(i));
          end
        end
        top_d = top_q + TW'(len) - TW'(1);
      end
      ll1ep_pkg::STK_CLEAR: begin
        stack_d[0] = ll1ep_pkg::SYM_END;
        stack_d[1] = ll1ep_pkg::SYM_E;
        top_d      = TW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < DW; j++) begin
        stack_q[j] <= (j == 1) ? ll1ep_pkg::SYM_E : ll1ep_pkg::SYM_END;
      end
      top_q <= TW'(1);
    end else begin
      stack_q <= stack_d;
      top_q   <= top_d;
    end
  end

  assign stat_o.top_sym = stack_q[top_q];
  assign stat_o.top_idx = top_q;

endmodule

[hw/rtl/ll1_expression_parser.sv]
// Top level of the table-driven LL(1) parser for the expression grammar.
`timescale 1ns / 1ps

//  channel | signals                                   | direction | one beat
//  --------+-------------------------------------------+-----------+-------------------------
//  in      | in_valid_i, in_ready_o, symbol_i          | sink      | one input character
//  out     | out_valid_o, out_ready_i, event_res_o,    | source    | one parser event
//          | production_o, last_o                      |           |
//
//  Flow: the fetch step takes the character, then the step loop issues one result
//  per cycle unless the output register stalls it, 1 to 5 results per character;
//  the single stack update per step in the loop sets that rate.
//  Stalls: a result waits in the output register; the step loop holds while
//  that register is full and not drained.
//  Reset: asynchronous, active low; the stack comes up as '#' below E.

module ll1_expression_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] symbol_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] event_res_o,
  output logic [3:0] production_o,
  output logic       last_o
);

  // Microcode sequencer: step counter plus the control word it selects
  logic [ll1ep_pkg::UC_W-1:0] step_q, step_d;
  ll1ep_pkg::ucode_t          uc;

  // Character class of the beat being worked on, and results issued so far
  logic [3:0] cls_q;
  logic [2:0] n_q, n_d;

  // Output register
  logic       out_valid_q;
  logic [2:0] ev_q;
  logic [3:0] prod_q;
  logic       last_q;

  // Step decision
  logic                   in_beat;
  logic                   can_emit;
  logic                   fire;
  logic [2:0]             ev_c;
  logic [3:0]             prod_c;
  logic                   last_c;
  logic [3:0]             rule;
  logic [1:0]             len;
  logic [ll1ep_pkg::TOP_W:0] new_top;
  logic                   is_nt;
  ll1ep_pkg::stack_cmd_t  cmd_c;
  ll1ep_pkg::stack_cmd_t  cmd;
  ll1ep_pkg::stack_stat_t stat;

  assign uc        = ll1ep_pkg::ucode_rom(step_q);
  assign in_ready_o = uc.in_rdy;
  assign in_beat   = in_valid_i & uc.in_rdy;
  assign can_emit  = ~out_valid_q | out_ready_i;
  assign fire      = uc.exec & can_emit;

  assign is_nt   = (stat.top_sym >= ll1ep_pkg::SYM_E) && (stat.top_sym <= ll1ep_pkg::SYM_F);
  assign rule    = ll1ep_pkg::parse_rule(stat.top_sym, cls_q);
  assign len     = ll1ep_pkg::rhs_len(rule);
  assign new_top = {1'b0, stat.top_idx} + (ll1ep_pkg::TOP_W+1)'(len)
                   - (ll1ep_pkg::TOP_W+1)'(1);

  // One parse step: pick the event and the stack operation it implies
  always_comb begin
    ev_c   = ll1ep_pkg::EV_SYNTAX;
    prod_c = 4'd0;
    last_c = 1'b1;
    cmd_c  = '{op: ll1ep_pkg::STK_CLEAR, rule: 4'd0};
    if (cls_q == ll1ep_pkg::SYM_BAD) begin
      ev_c = ll1ep_pkg::EV_BADCH;
    end else if (is_nt) begin
      if (n_q >= 3'd4 || rule == 4'd0) begin
        // runaway expansion or empty table entry
        ev_c = ll1ep_pkg::EV_SYNTAX;
      end else if (len != 2'd0 &&
                   new_top >= (ll1ep_pkg::TOP_W+1)'(ll1ep_pkg::STACK_DEPTH)) begin
        ev_c = ll1ep_pkg::EV_OVF;
      end else begin
        ev_c   = ll1ep_pkg::EV_PROD;
        prod_c = rule;
        last_c = 1'b0;
        cmd_c  = '{op: (len == 2'd0) ? ll1ep_pkg::STK_POP : ll1ep_pkg::STK_EXPAND,
                   rule: rule};
      end
    end else if (stat.top_sym == cls_q) begin
      if (cls_q == ll1ep_pkg::SYM_END) begin
        ev_c = ll1ep_pkg::EV_ACCEPT;
      end else begin
        ev_c  = ll1ep_pkg::EV_MATCH;
        cmd_c = '{op: ll1ep_pkg::STK_POP, rule: 4'd0};
      end
    end
  end

  // Drop the stack command unless the result actually goes out this cycle
  assign cmd = fire ? cmd_c : '{op: ll1ep_pkg::STK_NONE, rule: 4'd0};

  ll1ep_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  // Next step from the jump condition of the current control word
  always_comb begin
    step_d = step_q;
    n_d    = n_q;
    unique case (uc.jc)
      ll1ep_pkg::JC_IN_BEAT: if (in_beat) step_d = uc.target;
      ll1ep_pkg::JC_LAST:    if (fire && last_c) step_d = uc.target;
      ll1ep_pkg::JC_ALWAYS:  step_d = uc.target;
      default:               step_d = uc.target;
    endcase
    if (in_beat) begin
      n_d = 3'd0;
    end else if (fire) begin
      n_d = n_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ll1ep_pkg::UC_FETCH;
      n_q         <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      n_q    <= n_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture the class on a beat, hold results until taken
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      cls_q <= ll1ep_pkg::classify(symbol_i);
    end
    if (fire) begin
      ev_q   <= ev_c;
      prod_q <= prod_c;
      last_q <= last_c;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_res_o  = ev_q;
  assign production_o = prod_q;
  assign last_o       = last_q;

endmodule

[hw/rtl/ll1ep_checker.sv]
// Port-level checks for the LL(1) parser, bound to the top level.
`timescale 1ns / 1ps

module ll1ep_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] symbol_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] event_res_o,
  input logic [3:0] production_o,
  input logic       last_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_res_o)
      && $stable(production_o) && $stable(last_o))
    else $error("result changed while stalled");

  // Productions carry a rule number and never end a character
  a_prod_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == ll1ep_pkg::EV_PROD |->
      production_o != 4'd0 && production_o <= 4'd8 && !last_o)
    else $error("production result malformed");

  // Every other event ends the character and carries no rule
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != ll1ep_pkg::EV_PROD |->
      production_o == 4'd0 && last_o && event_res_o <= ll1ep_pkg::EV_OVF)
    else $error("terminal result malformed");

  // One character at a time: no new beat right after one is taken
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

endmodule

bind ll1_expression_parser ll1ep_checker u_ll1ep_checker (.*);

[bench/ll1_parse_checker.sv]
// Scoreboard for the LL(1) parser: predicts the events of each character and checks them.
`timescale 1ns / 1ps

module ll1_parse_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] symbol_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [2:0] event_res_i,
  input  logic [3:0] production_i,
  input  logic       last_i,
  output int         mismatch_count_o,
  output int         pending_o,
  output int         results_o,
  output int         accepts_o,
  output int         errors_o,
  output int         overflows_o
);

  localparam int MAX_EVENTS = 5;
  localparam int REPORT_MAX = 10;

  // Lookahead columns of the parse table
  localparam int COL_ID   = 0;
  localparam int COL_PLUS = 1;
  localparam int COL_STAR = 2;
  localparam int COL_LP   = 3;
  localparam int COL_RP   = 4;
  localparam int COL_END  = 5;

  // Grammar rules
  localparam logic [3:0] RULE_NONE     = 4'd0;
  localparam logic [3:0] RULE_E_TEP    = 4'd1;
  localparam logic [3:0] RULE_EP_PLUS  = 4'd2;
  localparam logic [3:0] RULE_EP_EMPTY = 4'd3;
  localparam logic [3:0] RULE_T_FTP    = 4'd4;
  localparam logic [3:0] RULE_TP_STAR  = 4'd5;
  localparam logic [3:0] RULE_TP_EMPTY = 4'd6;
  localparam logic [3:0] RULE_F_PAREN  = 4'd7;
  localparam logic [3:0] RULE_F_ID     = 4'd8;

  typedef struct packed {
    logic [2:0] ev;
    logic [3:0] prod;
    logic       last;
  } parse_event_t;

  parse_event_t expected_events[$];
  logic [3:0]   sym_stack [ll1ep_pkg::STACK_DEPTH];
  int           sp;
  int           mismatches;
  int           results;
  int           accepts;
  int           errors;
  int           overflows;

  function automatic logic [3:0] char_class(input logic [7:0] c);
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return ll1ep_pkg::SYM_ID;
    case (c)
      "+":     return ll1ep_pkg::SYM_PLUS;
      "*":     return ll1ep_pkg::SYM_STAR;
      "(":     return ll1ep_pkg::SYM_LP;
      ")":     return ll1ep_pkg::SYM_RP;
      "#":     return ll1ep_pkg::SYM_END;
      default: return ll1ep_pkg::SYM_BAD;
    endcase
  endfunction

  function automatic int lookahead_col(input logic [3:0] cls);
    case (cls)
      ll1ep_pkg::SYM_ID:   return COL_ID;
      ll1ep_pkg::SYM_PLUS: return COL_PLUS;
      ll1ep_pkg::SYM_STAR: return COL_STAR;
      ll1ep_pkg::SYM_LP:   return COL_LP;
      ll1ep_pkg::SYM_RP:   return COL_RP;
      default:             return COL_END;
    endcase
  endfunction

  function automatic logic [3:0] table_rule(input logic [3:0] nt, input int col);
    logic [23:0] row;  // columns #, ), (, *, +, i from high nibble to low
    case (nt)
      ll1ep_pkg::SYM_E:  row = {RULE_NONE, RULE_NONE, RULE_E_TEP, RULE_NONE, RULE_NONE,
                                RULE_E_TEP};
      ll1ep_pkg::SYM_EP: row = {RULE_EP_EMPTY, RULE_EP_EMPTY, RULE_NONE, RULE_NONE,
                                RULE_EP_PLUS, RULE_NONE};
      ll1ep_pkg::SYM_T:  row = {RULE_NONE, RULE_NONE, RULE_T_FTP, RULE_NONE, RULE_NONE,
                                RULE_T_FTP};
      ll1ep_pkg::SYM_TP: row = {RULE_TP_EMPTY, RULE_TP_EMPTY, RULE_NONE, RULE_TP_STAR,
                                RULE_TP_EMPTY, RULE_NONE};
      ll1ep_pkg::SYM_F:  row = {RULE_NONE, RULE_NONE, RULE_F_PAREN, RULE_NONE, RULE_NONE,
                                RULE_F_ID};
      default:           row = '0;
    endcase
    return row[col*4 +: 4];
  endfunction

  task automatic clear_stack();
    foreach (sym_stack[i]) sym_stack[i] = ll1ep_pkg::SYM_END;
    sym_stack[1] = ll1ep_pkg::SYM_E;
    sp = 1;
  endtask

  task automatic note_event(input logic [2:0] ev, input logic [3:0] prod, input logic last);
    expected_events.push_back('{ev: ev, prod: prod, last: last});
    if (ev == ll1ep_pkg::EV_ACCEPT) accepts++;
    if (ev == ll1ep_pkg::EV_BADCH || ev == ll1ep_pkg::EV_SYNTAX) errors++;
    if (ev == ll1ep_pkg::EV_OVF) overflows++;
  endtask

  // Walk the stack for one character: expand nonterminals, then match or fail.
  task automatic parse_char(input logic [7:0] c);
    logic [3:0] cls;
    logic [3:0] top;
    logic [3:0] rule;
    logic [3:0] rhs [3];
    int         col;
    int         n;
    int         len;
    bit         done;
    cls  = char_class(c);
    n    = 0;
    done = 1'b0;
    if (cls == ll1ep_pkg::SYM_BAD) begin
      note_event(ll1ep_pkg::EV_BADCH, RULE_NONE, 1'b1);
      clear_stack();
      done = 1'b1;
    end
    col = lookahead_col(cls);
    while (!done) begin
      top = sym_stack[sp];
      if (top >= ll1ep_pkg::SYM_E && top <= ll1ep_pkg::SYM_F) begin
        rule = table_rule(top, col);
        if (n >= MAX_EVENTS - 1 || rule == RULE_NONE) begin
          note_event(ll1ep_pkg::EV_SYNTAX, RULE_NONE, 1'b1);
          clear_stack();
          done = 1'b1;
        end else begin
          // right-hand side, deepest symbol first
          rhs[0] = ll1ep_pkg::SYM_END;
          rhs[1] = ll1ep_pkg::SYM_END;
          rhs[2] = ll1ep_pkg::SYM_END;
          case (rule)
            RULE_E_TEP: begin
              len = 2; rhs[0] = ll1ep_pkg::SYM_EP; rhs[1] = ll1ep_pkg::SYM_T;
            end
            RULE_EP_PLUS: begin
              len = 3; rhs[0] = ll1ep_pkg::SYM_EP; rhs[1] = ll1ep_pkg::SYM_T;
              rhs[2] = ll1ep_pkg::SYM_PLUS;
            end
            RULE_T_FTP: begin
              len = 2; rhs[0] = ll1ep_pkg::SYM_TP; rhs[1] = ll1ep_pkg::SYM_F;
            end
            RULE_TP_STAR: begin
              len = 3; rhs[0] = ll1ep_pkg::SYM_TP; rhs[1] = ll1ep_pkg::SYM_F;
              rhs[2] = ll1ep_pkg::SYM_STAR;
            end
            RULE_F_PAREN: begin
              len = 3; rhs[0] = ll1ep_pkg::SYM_RP; rhs[1] = ll1ep_pkg::SYM_E;
              rhs[2] = ll1ep_pkg::SYM_LP;
            end
            RULE_F_ID: begin
              len = 1; rhs[0] = ll1ep_pkg::SYM_ID;
            end
            default: len = 0;
          endcase
          if (len > 0 && sp + len - 1 >= ll1ep_pkg::STACK_DEPTH) begin
            note_event(ll1ep_pkg::EV_OVF, RULE_NONE, 1'b1);
            clear_stack();
            done = 1'b1;
          end else begin
            if (len == 0) begin
              sp = (sp > 0) ? sp - 1 : 0;
            end else begin
              for (int i = 0; i < len; i++) sym_stack[sp + i] = rhs[i];
              sp = sp + len - 1;
            end
            note_event(ll1ep_pkg::EV_PROD, rule, 1'b0);
            n++;
          end
        end
      end else if (top == cls) begin
        if (cls == ll1ep_pkg::SYM_END) begin
          note_event(ll1ep_pkg::EV_ACCEPT, RULE_NONE, 1'b1);
          clear_stack();
        end else begin
          note_event(ll1ep_pkg::EV_MATCH, RULE_NONE, 1'b1);
          sp = (sp > 0) ? sp - 1 : 0;
        end
        done = 1'b1;
      end else begin
        note_event(ll1ep_pkg::EV_SYNTAX, RULE_NONE, 1'b1);
        clear_stack();
        done = 1'b1;
      end
    end
  endtask

  task automatic check_result();
    parse_event_t want;
    results++;
    if (expected_events.size() == 0) begin
      if (mismatches < REPORT_MAX)
        $display("[%0t] unexpected result: ev=%0d prod=%0d last=%0d", $realtime,
                 event_res_i, production_i, last_i);
      mismatches++;
    end else begin
      want = expected_events.pop_front();
      if (want.ev !== event_res_i || want.prod !== production_i || want.last !== last_i) begin
        if (mismatches < REPORT_MAX)
          $display("[%0t] result %0d mismatch: expected ev=%0d prod=%0d last=%0d, ",
                   $realtime, results, want.ev, want.prod, want.last,
                   "got ev=%0d prod=%0d last=%0d",
                   event_res_i, production_i, last_i);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_stack();
      expected_events.delete();
    end else begin
      // results leaving now belong to earlier characters, so check them first
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) parse_char(symbol_i);
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_events.size();
    results_o        <= results;
    accepts_o        <= accepts;
    errors_o         <= errors;
    overflows_o      <= overflows;
  end

endmodule

[bench/tb_top.sv]
// Testbench top for the LL(1) expression parser: clock, reset, character stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_CHARS      = 470;
  localparam int WATCHDOG_LIMIT = 2000;  // idle cycles with no beat on either channel
  localparam int DRAIN_CYCLES   = 20;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] symbol    = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] event_res;
  logic [3:0] production;
  logic       res_last;

  int mismatches;
  int pending;
  int results;
  int accepts;
  int errors;
  int overflows;

  logic [7:0] text_q[$];  // characters waiting to be driven
  int         chars_sent;
  int         directed_chars;
  int         stream_left;
  int         idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  ll1_expression_parser DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .symbol_i     (symbol),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .event_res_o  (event_res),
    .production_o (production),
    .last_o       (res_last)
  );

  ll1_parse_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .symbol_i         (symbol),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .event_res_i      (event_res),
    .production_i     (production),
    .last_i           (res_last),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .results_o        (results),
    .accepts_o        (accepts),
    .errors_o         (errors),
    .overflows_o      (overflows)
  );

  // Gap before the next character beat: mostly none or short, now and then long,
  // with occasional streaming stretches that keep valid high back to back.
  function automatic int pick_gap();
    int r;
    if (stream_left > 0) begin
      stream_left--;
      return 0;
    end
    if ($urandom_range(0, 59) == 0) begin
      stream_left = $urandom_range(30, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] random_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
  endfunction

  // Any grammar token, or once in a while a raw byte from the full range.
  function automatic logic [7:0] random_token();
    case ($urandom_range(0, 6))
      0:       return "+";
      1:       return "*";
      2:       return "(";
      3:       return ")";
      4:       return "#";
      5:       return 8'($urandom_range(0, 255));
      default: return random_letter();
    endcase
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Build a well-formed expression ended by '#': operands are letters or
  // parenthesized groups up to max_depth, joined by '+' or '*'.
  task automatic gen_expression(input int max_depth, input int max_operands);
    int depth;
    int operands;
    bit stop;
    depth    = 0;
    operands = 0;
    stop     = 1'b0;
    while (!stop) begin
      while (depth < max_depth && $urandom_range(0, 2) == 0) begin
        text_q.push_back("(");
        depth++;
      end
      text_q.push_back(random_letter());
      operands++;
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        text_q.push_back(")");
        depth--;
      end
      if (operands >= max_operands) begin
        for (; depth > 0; depth--) text_q.push_back(")");
        stop = 1'b1;
      end else begin
        text_q.push_back($urandom_range(0, 1) ? "+" : "*");
      end
    end
    text_q.push_back("#");
  endtask

  // Drive every queued character as one beat; hold valid and payload until taken.
  task automatic send_text();
    int gap;
    while (text_q.size() > 0) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid <= 1'b1;
      symbol   <= text_q.pop_front();
      @(posedge clk_i);
      while (!in_ready) @(posedge clk_i);
      chars_sent++;
    end
  endtask

  // Output back-pressure: short stalls mostly, some long ones, and stretches
  // where ready stays high for a good while.
  initial begin : ready_gen
    int  hold;
    bit  level;
    int  r;
    hold  = 0;
    level = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold == 0) begin
        r     = $urandom_range(0, 99);
        level = !level;
        if (level) hold = (r < 10) ? $urandom_range(40, 150) : $urandom_range(1, 8);
        else if (r < 80) hold = $urandom_range(1, 3);
        else if (r < 95) hold = $urandom_range(4, 12);
        else hold = $urandom_range(20, 60);
      end
      out_ready <= level;
      hold--;
    end
  end

  // Watchdog: end the run when neither channel moves a beat for too long.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles, %0d results still expected",
               idle_cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int r;
    int opens;
    int idx;
    chars_sent  = 0;
    stream_left = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every rule and the letter extremes, then each failure path.
    push_text("A+z*(Z)#");  // all eight rules plus accept
    push_text("#");         // empty table entry: E facing end of string
    push_text(")");         // empty table entry: E facing ')'
    text_q.push_back(8'h00);  // unknown characters at both byte extremes
    text_q.push_back(8'hff);
    push_text("(((((");     // fifth open paren runs the stack over
    push_text("(a#");       // ')' on top meets '#': terminal mismatch
    push_text("a(");        // T' facing '(': empty table entry
    directed_chars = text_q.size();
    send_text();

    // Random: mostly well-formed strings, the rest broken strings and noise.
    while (chars_sent < NUM_CHARS) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        gen_expression($urandom_range(0, 3), $urandom_range(1, 5));
      end else if (r < 82) begin
        gen_expression($urandom_range(0, 3), $urandom_range(1, 5));
        if ($urandom_range(0, 2) == 0) begin
          void'(text_q.pop_back());  // drop the end mark; the next string continues
        end else begin
          idx = $urandom_range(0, text_q.size() - 1);
          text_q[idx] = random_token();
        end
      end else if (r < 90) begin
        repeat ($urandom_range(1, 8)) text_q.push_back(random_token());
      end else if (r < 95) begin
        repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        // deep nesting: four opens still fit, more overflow
        opens = $urandom_range(4, 7);
        repeat (opens) text_q.push_back("(");
        text_q.push_back(random_letter());
        repeat (opens) text_q.push_back(")");
        text_q.push_back("#");
      end
      send_text();
    end
    in_valid <= 1'b0;

    // Drain: let the count catch up with the last beat, wait for every predicted
    // event, then watch a little longer for strays.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Drove %0d characters (%0d directed) and checked %0d parser events.",
             chars_sent, directed_chars, results);
    $display("Strings accepted: %0d, error events: %0d, stack overflows: %0d.",
             accepts, errors, overflows);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
